@@ design/sha_pkg.sv @@
`default_nettype none
package sha_pkg;

  localparam int QDepth = 4;
  localparam int QAw = 2;

  typedef struct packed {
    logic       fin;
    logic [7:0] data;
  } sha_item_t;

  typedef logic [31:0] word_t;

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_h(input logic [2:0] idx);
    word_t h;
    case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85; 3'd2: h = 32'h3c6ef372;
      3'd3: h = 32'ha54ff53a; 3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  localparam logic [7:0] PadByte = 8'h80;

endpackage
`default_nettype wire

@@ design/sha_front.sv @@
`default_nettype none
module sha_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic               in_req_type,
  input  wire logic [7:0]         in_byte_value,
  output sha_pkg::sha_item_t      q_item,
  output logic                    q_valid,
  input  wire logic               q_take
);
  import sha_pkg::*;

  sha_item_t        mem_r [QDepth];
  logic [QAw:0]     cnt_r;
  logic [QAw-1:0]   wp_r, rp_r;
  logic             wr, rd;

  assign in_full = (cnt_r == (QAw+1)'(QDepth));
  assign wr      = in_push && !in_full;
  assign q_valid = (cnt_r != '0);
  assign rd      = q_take && q_valid;
  assign q_item  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= '{fin: in_req_type, data: in_byte_value};
    end
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= '0;
      rp_r  <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAw+1)'(wr) - (QAw+1)'(rd);
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAw+1)'(QDepth)) else $error("queue overflow");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (wr && !rd) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("count slip");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> !rd) else $error("read when empty");
endmodule
`default_nettype wire

@@ design/sha_back.sv @@
`default_nettype none
module sha_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sha_pkg::sha_item_t q_item,
  input  wire logic               q_valid,
  output logic                    q_take,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic [63:0]             out_digest_word,
  output logic [1:0]              out_word_index,
  output logic                    out_last_word
);
  import sha_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PAD, S_RUN, S_ADD, S_EMIT} state_t;

  state_t      st_r;
  // block held as 16 big-endian words; during the rounds it doubles as the schedule window
  word_t       buf_r [16];
  logic [5:0]  fill_r, ptr_r;
  logic [63:0] len_r;
  word_t       h_r [8];
  word_t       v_r [8];
  logic [5:0]  rnd_r;
  logic        fin_r, second_r;
  logic [1:0]  widx_r;
  logic        ovf_r;

  word_t s0, s1, ws, wi, t1, t2, e, a;

  function automatic word_t rr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    s0 = rr(buf_r[1], 7) ^ rr(buf_r[1], 18) ^ (buf_r[1] >> 3);
    s1 = rr(buf_r[14], 17) ^ rr(buf_r[14], 19) ^ (buf_r[14] >> 10);
    ws = buf_r[0] + s0 + buf_r[9] + s1;
    wi = buf_r[0];
    e  = v_r[4];
    a  = v_r[0];
    t1 = v_r[7] + (rr(e, 6) ^ rr(e, 11) ^ rr(e, 25)) + ((e & v_r[5]) ^ (~e & v_r[6]))
         + round_k(rnd_r) + wi;
    t2 = (rr(a, 2) ^ rr(a, 13) ^ rr(a, 22)) + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  assign q_take          = (st_r == S_IDLE) && q_valid;
  assign out_empty       = (st_r != S_EMIT);
  assign out_digest_word = {h_r[{widx_r, 1'b0}], h_r[{widx_r, 1'b1}]};
  assign out_word_index  = widx_r;
  assign out_last_word   = (widx_r == 2'd3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      fill_r <= '0;
      len_r  <= '0;
      widx_r <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
    end else begin
      case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            fin_r <= q_item.fin;
            if (!q_item.fin) begin
              buf_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= q_item.data;
              fill_r <= fill_r + 1'b1;
              len_r  <= len_r + 64'd8;
            end else begin
              buf_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= PadByte;
              ovf_r    <= (fill_r > 6'd55);
              second_r <= 1'b0;
              ptr_r    <= fill_r + 1'b1;
            end
            if (fill_r == 6'd63) begin
              for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
              rnd_r <= '0;
              st_r  <= S_RUN;
            end else if (q_item.fin) begin
              rnd_r <= '0;
              st_r  <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // one pad byte a cycle; length goes in the last eight unless overflow block
          if (!ovf_r && ptr_r >= 6'd56)
            buf_r[ptr_r[5:2]][{~ptr_r[1:0], 3'b000} +: 8] <= len_r[{~ptr_r[2:0], 3'b000} +: 8];
          else
            buf_r[ptr_r[5:2]][{~ptr_r[1:0], 3'b000} +: 8] <= 8'h00;
          ptr_r <= ptr_r + 1'b1;
          if (ptr_r == 6'd63) begin
            st_r  <= S_RUN;
            rnd_r <= '0;
            for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
          end
        end
        S_RUN: begin
          for (int i = 0; i < 15; i++) buf_r[i] <= buf_r[i+1];
          buf_r[15] <= ws;
          v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4]; v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0]; v_r[0] <= t1 + t2;
          rnd_r <= rnd_r + 1'b1;
          if (rnd_r == 6'd63) st_r <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          fill_r <= '0;
          if (!fin_r) begin
            st_r <= S_IDLE;
          end else if (ovf_r && !second_r) begin
            second_r <= 1'b1;
            ovf_r    <= 1'b0;
            ptr_r    <= '0;
            st_r     <= S_PAD;
          end else begin
            widx_r <= '0;
            st_r   <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_pop) begin
            widx_r <= widx_r + 1'b1;
            if (widx_r == 2'd3) begin
              st_r   <= S_IDLE;
              len_r  <= '0;
              for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> st_r == S_IDLE) else $error("take while busy");
  a_emit_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_ADD && !fin_r) |=> st_r == S_IDLE) else $error("absorb emitted");
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RUN && rnd_r != 6'd63) |=> st_r == S_RUN) else $error("short run");
endmodule
`default_nettype wire

@@ design/sha256_stream_hasher.sv @@
// channel | ports                           | accepted when
// input   | in_req_type, in_byte_value      | in_push && !in_full
// result  | out_digest_word/word_index/last | out_pop && !out_empty
// Absorb writes each byte into the block; the 64th byte of a block starts the rounds, then the add.
// Finish: pad bytes one a cycle (up to 64 per block), then a compression per block, 1 or 2 blocks.
// Round loop in the back end sets the rate; a 4-item queue lets input run ahead.
// Synchronous active-low reset restores the initial hash; no clearing pass.
// Digest words wait for pop; the queue fills meanwhile.
`default_nettype none
module sha256_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic        in_req_type,
  input  wire logic [7:0]  in_byte_value,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [63:0]      out_digest_word,
  output logic [1:0]       out_word_index,
  output logic             out_last_word
);
  import sha_pkg::*;

  sha_item_t q_item;
  logic      q_valid, q_take;

  sha_front u_front (.clk, .rst_n, .in_push, .in_full, .in_req_type, .in_byte_value,
                     .q_item, .q_valid, .q_take);
  sha_back  u_back  (.clk, .rst_n, .q_item, .q_valid, .q_take, .out_empty, .out_pop,
                     .out_digest_word, .out_word_index, .out_last_word);
endmodule
`default_nettype wire
